### src/spd_pkg.sv
// shared types and constants for the shortest path engine
package spd_pkg;

  localparam int unsigned NODE_BITS     = 10;
  localparam int unsigned NODE_COUNT    = 1 << NODE_BITS;
  localparam int unsigned EDGE_COUNT    = 8192;
  localparam int unsigned EDGE_IDX_BITS = $clog2(EDGE_COUNT);
  localparam int unsigned EDGE_CNT_BITS = $clog2(EDGE_COUNT + 1);
  localparam int unsigned WEIGHT_BITS   = 8;
  localparam int unsigned DIST_BITS     = 20;
  localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

  // transaction kinds carried in tuser
  localparam logic [1:0] KIND_ADD   = 2'd0;
  localparam logic [1:0] KIND_SOLVE = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;
  localparam logic [1:0] KIND_RSVD  = 2'd3;

  typedef struct packed {
    logic [NODE_BITS-1:0]   tail;
    logic [NODE_BITS-1:0]   head;
    logic [WEIGHT_BITS-1:0] weight;
  } edge_t;

  typedef struct packed {
    logic                 reached;
    logic [DIST_BITS-1:0] cost;
  } dist_entry_t;

  typedef struct packed {
    logic add;
    logic clear;
  } edge_cmd_t;

endpackage

### src/spd_edge_mem.sv
// edge store memory with fill count and sticky overflow flag
module spd_edge_mem
  import spd_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  edge_cmd_t                cmd_i,
  input  edge_t                    edge_i,
  input  logic [EDGE_IDX_BITS-1:0] rd_addr_i,
  output edge_t                    rd_data_o,
  output logic [EDGE_CNT_BITS-1:0] total_o,
  output logic                     overflow_o
);

  edge_t                    mem [EDGE_COUNT];
  edge_t                    rd_data_q;
  logic [EDGE_CNT_BITS-1:0] total_q, total_d;
  logic                     ovf_q, ovf_d;
  logic                     full;
  logic                     do_write;

  assign full     = (total_q == EDGE_CNT_BITS'(EDGE_COUNT));
  assign do_write = cmd_i.add && !full;

  // count and overflow bookkeeping
  always_comb begin
    total_d = total_q;
    ovf_d   = ovf_q;
    if (cmd_i.clear) begin
      total_d = '0;
      ovf_d   = 1'b0;
    end else if (cmd_i.add) begin
      if (full) begin
        ovf_d = 1'b1;
      end else begin
        total_d = total_q + EDGE_CNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      total_q <= total_d;
      ovf_q   <= ovf_d;
    end
  end

  // memory write and registered read
  always_ff @(posedge clk_i) begin
    if (do_write) begin
      mem[total_q[EDGE_IDX_BITS-1:0]] <= edge_i;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o  = rd_data_q;
  assign total_o    = total_q;
  assign overflow_o = ovf_q;

`ifndef SYNTH
  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= EDGE_CNT_BITS'(EDGE_COUNT))
    else $error("edge count beyond capacity");
  a_ovf_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovf_q) |-> $past(cmd_i.add && full))
    else $error("overflow set without a dropped edge");
  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear |=> ((total_q == '0) && !ovf_q))
    else $error("clear did not empty the edge store");
`endif

endmodule

### src/spd_dist_mem.sv
// per-node distance memory, one write port and two registered read ports
module spd_dist_mem
  import spd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 wr_en_i,
  input  logic [NODE_BITS-1:0] wr_addr_i,
  input  dist_entry_t          wr_data_i,
  input  logic [NODE_BITS-1:0] rd_a_addr_i,
  input  logic [NODE_BITS-1:0] rd_b_addr_i,
  output dist_entry_t          rd_a_o,
  output dist_entry_t          rd_b_o
);

  dist_entry_t mem [NODE_COUNT];
  dist_entry_t rd_a_q;
  dist_entry_t rd_b_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_a_q <= mem[rd_a_addr_i];
    rd_b_q <= mem[rd_b_addr_i];
  end

  assign rd_a_o = rd_a_q;
  assign rd_b_o = rd_b_q;

endmodule

### src/shortest_path_dijkstra_top.sv
// Single-source shortest path engine. Add-edge and clear transactions are
// accepted back to back. A solve transaction first sweeps the distance memory,
// then relaxes every stored edge in passes (edge read, distance read, update
// for each edge in turn), repeating passes until one makes no change: at most
// NODE_COUNT passes. The single distance memory port pair and the
// one-edge-at-a-time read-modify-write set the solve time. While a solve runs
// no input is taken; a finished result waits in an output register and does
// not block the next input.
module shortest_path_dijkstra_top
  import spd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // from_node[9:0], to_node[19:10], edge_weight[27:20], source_node[37:28],
  // target_node[47:38]
  input  logic [47:0] s_axis_tdata,
  // kind[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // reachable[0], distance[20:1], edge_overflow[21], zero[23:22]
  output logic [23:0] m_axis_tdata
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CLEAR = 3'd1;
  localparam logic [2:0] ST_SEED  = 3'd2;
  localparam logic [2:0] ST_EREAD = 3'd3;
  localparam logic [2:0] ST_DREAD = 3'd4;
  localparam logic [2:0] ST_DUPD  = 3'd5;
  localparam logic [2:0] ST_FRD   = 3'd6;
  localparam logic [2:0] ST_FIN   = 3'd7;

  logic [2:0]               state_q, state_d;
  logic [NODE_BITS-1:0]     src_q, src_d;
  logic [NODE_BITS-1:0]     tgt_q, tgt_d;
  logic [NODE_BITS-1:0]     clr_idx_q, clr_idx_d;
  logic [EDGE_IDX_BITS-1:0] edge_idx_q, edge_idx_d;
  logic                     changed_q, changed_d;
  logic                     out_valid_q, out_valid_d;
  logic                     out_reach_q;
  logic [DIST_BITS-1:0]     out_dist_q;
  logic                     out_ovf_q;

  logic                     in_accept;
  logic [1:0]               kind;
  edge_t                    in_edge;
  edge_cmd_t                edge_cmd;
  edge_t                    edge_rd;
  logic [EDGE_CNT_BITS-1:0] edge_total;
  logic                     overflow;

  logic                     dist_we;
  logic [NODE_BITS-1:0]     dist_waddr;
  dist_entry_t              dist_wdata;
  logic [NODE_BITS-1:0]     dist_raddr_a;
  dist_entry_t              dist_a;
  dist_entry_t              dist_b;

  logic [DIST_BITS:0]       sum;
  logic [DIST_BITS-1:0]     cand;
  logic                     relax;
  logic                     last_edge;
  logic                     out_free;
  logic                     load_out;

  assign kind      = s_axis_tuser;
  assign in_edge   = '{tail: s_axis_tdata[9:0], head: s_axis_tdata[19:10],
                       weight: s_axis_tdata[27:20]};
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_accept = s_axis_tvalid && s_axis_tready;

  assign edge_cmd = '{add:   in_accept && (kind == KIND_ADD),
                      clear: in_accept && (kind == KIND_CLEAR)};

  spd_edge_mem u_edge_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (edge_cmd),
    .edge_i     (in_edge),
    .rd_addr_i  (edge_idx_q),
    .rd_data_o  (edge_rd),
    .total_o    (edge_total),
    .overflow_o (overflow)
  );

  spd_dist_mem u_dist_mem (
    .clk_i       (clk_i),
    .wr_en_i     (dist_we),
    .wr_addr_i   (dist_waddr),
    .wr_data_i   (dist_wdata),
    .rd_a_addr_i (dist_raddr_a),
    .rd_b_addr_i (edge_rd.head),
    .rd_a_o      (dist_a),
    .rd_b_o      (dist_b)
  );

  // relaxation of the current edge: port a holds the tail, port b the head
  assign sum   = {1'b0, dist_a.cost} + (DIST_BITS + 1)'(edge_rd.weight);
  assign cand  = sum[DIST_BITS] ? DIST_MAX : sum[DIST_BITS-1:0];
  assign relax = dist_a.reached && (!dist_b.reached || (cand < dist_b.cost));
  assign last_edge = ({1'b0, edge_idx_q} == (edge_total - EDGE_CNT_BITS'(1)));

  assign dist_raddr_a = (state_q == ST_DREAD) ? edge_rd.tail : tgt_q;
  assign out_free     = !out_valid_q || m_axis_tready;
  assign load_out     = (state_q == ST_FIN) && out_free;

  // solve sequencer
  always_comb begin
    state_d    = state_q;
    src_d      = src_q;
    tgt_d      = tgt_q;
    clr_idx_d  = clr_idx_q;
    edge_idx_d = edge_idx_q;
    changed_d  = changed_q;
    dist_we    = 1'b0;
    dist_waddr = clr_idx_q;
    dist_wdata = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept && (kind == KIND_SOLVE)) begin
          src_d     = s_axis_tdata[37:28];
          tgt_d     = s_axis_tdata[47:38];
          clr_idx_d = '0;
          state_d   = ST_CLEAR;
        end
      end
      ST_CLEAR: begin
        dist_we   = 1'b1;
        clr_idx_d = clr_idx_q + NODE_BITS'(1);
        if (clr_idx_q == NODE_BITS'(NODE_COUNT - 1)) begin
          state_d = ST_SEED;
        end
      end
      ST_SEED: begin
        dist_we    = 1'b1;
        dist_waddr = src_q;
        dist_wdata = '{reached: 1'b1, cost: '0};
        edge_idx_d = '0;
        changed_d  = 1'b0;
        state_d    = (edge_total == '0) ? ST_FRD : ST_EREAD;
      end
      ST_EREAD: state_d = ST_DREAD;
      ST_DREAD: state_d = ST_DUPD;
      ST_DUPD: begin
        dist_waddr = edge_rd.head;
        dist_wdata = '{reached: 1'b1, cost: cand};
        dist_we    = relax;
        if (last_edge) begin
          edge_idx_d = '0;
          changed_d  = 1'b0;
          state_d    = (changed_q || relax) ? ST_EREAD : ST_FRD;
        end else begin
          edge_idx_d = edge_idx_q + EDGE_IDX_BITS'(1);
          changed_d  = changed_q || relax;
          state_d    = ST_EREAD;
        end
      end
      ST_FRD: state_d = ST_FIN;
      ST_FIN: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      clr_idx_q  <= '0;
      edge_idx_q <= '0;
      changed_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_idx_q  <= clr_idx_d;
      edge_idx_q <= edge_idx_d;
      changed_q  <= changed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    src_q <= src_d;
    tgt_q <= tgt_d;
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tvalid && m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_reach_q <= dist_a.reached;
      out_dist_q  <= dist_a.reached ? dist_a.cost : '0;
      out_ovf_q   <= overflow;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_ovf_q, out_dist_q, out_reach_q};

`ifndef SYNTH
  a_solve_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && (kind == KIND_SOLVE)) |=> (state_q == ST_CLEAR))
    else $error("solve transaction did not start the distance sweep");
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> (!out_valid_q || m_axis_tready))
    else $error("result loaded over a pending transaction");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(state_q == ST_DUPD) |-> !$past(in_accept))
    else $error("input taken during a solve");
`endif

endmodule
